// ----- hw/rtl/dam_pkg.sv -----
// ----------------------------------------------------------------------------
// dam_pkg
// Shared types and constants of the decimal accumulator machine.
// ----------------------------------------------------------------------------
package dam_pkg;

   localparam int MEM_WORDS = 100;
   localparam int ADDR_W    = 7;
   localparam int WORD_W    = 32;
   localparam int STAT_W    = 3;

   localparam logic [STAT_W-1:0] ST_RUN     = 3'd0;
   localparam logic [STAT_W-1:0] ST_HALT    = 3'd1;
   localparam logic [STAT_W-1:0] ST_DIVZ    = 3'd2;
   localparam logic [STAT_W-1:0] ST_BADOP   = 3'd3;
   localparam logic [STAT_W-1:0] ST_IGNORED = 3'd4;

   // opcodes
   localparam logic [5:0] OP_READ  = 6'd10;
   localparam logic [5:0] OP_WRITE = 6'd11;
   localparam logic [5:0] OP_LOAD  = 6'd20;
   localparam logic [5:0] OP_STORE = 6'd21;
   localparam logic [5:0] OP_ADD   = 6'd30;
   localparam logic [5:0] OP_SUB   = 6'd31;
   localparam logic [5:0] OP_DIV   = 6'd32;
   localparam logic [5:0] OP_MUL   = 6'd33;
   localparam logic [5:0] OP_BR    = 6'd40;
   localparam logic [5:0] OP_BRNEG = 6'd41;
   localparam logic [5:0] OP_BRZERO = 6'd42;
   localparam logic [5:0] OP_HALT  = 6'd43;

   // legal instruction words span 1000..4399
   localparam int WORD_MIN = 1000;
   localparam int WORD_MAX = 4399;
   // floor(w / 100) = (w * DIV100_MUL) >> DIV100_SHIFT for w < 8192
   localparam int DIV100_MUL   = 41944;
   localparam int DIV100_SHIFT = 22;

   typedef enum logic [1:0] {
      K_WRITE   = 2'd0,
      K_EXEC    = 2'd1,
      K_READ    = 2'd2,
      K_RESTART = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      RUN_GO    = 2'd0,
      RUN_HALT  = 2'd1,
      RUN_DIVZ  = 2'd2,
      RUN_BADOP = 2'd3
   } run_type;

   typedef struct packed {
      kind_type                 kind;
      logic [ADDR_W-1:0]        addr;
      logic signed [WORD_W-1:0] data;
      logic signed [WORD_W-1:0] read_value;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_type;

endpackage

// ----- hw/rtl/dam_front.sv -----
// ----------------------------------------------------------------------------
// dam_front
// Input side: takes request transfers and queues them for the executor.
// ----------------------------------------------------------------------------
module dam_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_kind,
   input  logic [dam_pkg::ADDR_W-1:0]  req_addr,
   input  logic signed [dam_pkg::WORD_W-1:0] req_data,
   input  logic signed [dam_pkg::WORD_W-1:0] req_read_value,
   output dam_pkg::queue_type          head,
   input  logic                        pop
);

   dam_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   logic       take;
   dam_pkg::item_type item_in;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign take      = pop && (count_ff != 2'd0);

   always_comb begin
      item_in.kind       = dam_pkg::kind_type'(req_kind);
      item_in.addr       = req_addr;
      item_in.data       = req_data;
      item_in.read_value = req_read_value;
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (take) rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !take) count_ff <= count_ff + 2'd1;
         else if (take && !push) count_ff <= count_ff - 2'd1;
      end
   end

endmodule

// ----- hw/rtl/dam_back.sv -----
// ----------------------------------------------------------------------------
// dam_back
// Executor: memory, accumulator, instruction counter, iterative divider and
// the response register.
// ----------------------------------------------------------------------------
module dam_back #(
   parameter int MEM_WORDS = dam_pkg::MEM_WORDS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dam_pkg::queue_type          head,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [dam_pkg::STAT_W-1:0]  rsp_status,
   output logic [dam_pkg::ADDR_W-1:0]  rsp_pc,
   output logic signed [dam_pkg::WORD_W-1:0] rsp_accumulator,
   output logic                        rsp_out_valid,
   output logic [dam_pkg::ADDR_W-1:0]  rsp_out_addr,
   output logic signed [dam_pkg::WORD_W-1:0] rsp_out_data
);

   localparam int AW = dam_pkg::ADDR_W;
   localparam int WW = dam_pkg::WORD_W;

   typedef enum logic [2:0] {
      S_IDLE, S_MEMRD, S_FETCH, S_OPRD, S_EXEC, S_DIV, S_DONE
   } state_type;

   state_type         state_ff;
   dam_pkg::run_type  run_ff;
   logic [AW-1:0]     pc_ff;
   logic [WW-1:0]     acc_ff;
   logic [WW-1:0]     rval_ff;
   logic              ign_ff;
   logic              ov_ff;
   logic [AW-1:0]     oa_ff;
   logic [WW-1:0]     od_ff;
   logic              bad_ff;
   logic [5:0]        op_ff;
   logic [AW-1:0]     opa_ff;
   logic [WW-1:0]     quo_ff, rem_ff, dvs_ff;
   logic              neg_ff;
   logic [4:0]        cnt_ff;

   logic              rsp_valid_ff;
   logic [dam_pkg::STAT_W-1:0] rsp_status_ff;
   logic [AW-1:0]     rsp_pc_ff, rsp_oa_ff;
   logic [WW-1:0]     rsp_acc_ff, rsp_od_ff;
   logic              rsp_ov_ff;

   // memory
   logic [WW-1:0]        mem_ff [MEM_WORDS];
   logic [MEM_WORDS-1:0] mem_vld_ff;
   logic [WW-1:0]        rd_data_ff;
   logic [AW-1:0]        rd_addr;
   logic                 we;
   logic [AW-1:0]        wa;
   logic [WW-1:0]        wd;

   // decode and helpers
   logic signed [WW-1:0] word_s;
   logic                 word_bad;
   logic [12:0]          w13;
   logic [28:0]          w_prod;
   logic [5:0]           w_op;
   logic [12:0]          w_ad;
   logic [AW-1:0]        pc_next;
   logic [WW-1:0]        m;
   logic                 na, nb;
   logic [WW-1:0]        ma, mb;
   logic [WW-1:0]        rem_sh;
   logic                 ge;
   logic [WW-1:0]        rem_new, quo_new;
   logic                 slot_free;

   assign pop       = (state_ff == S_IDLE) && head.valid;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign pc_next   = (pc_ff == AW'(MEM_WORDS - 1)) ? '0 : pc_ff + 1'b1;
   assign m         = rd_data_ff;

   assign word_s   = rd_data_ff;
   assign word_bad = (word_s < WW'(dam_pkg::WORD_MIN)) || (word_s > WW'(dam_pkg::WORD_MAX));
   assign w13      = rd_data_ff[12:0];
   assign w_prod   = 29'(w13) * 29'(dam_pkg::DIV100_MUL);
   assign w_op     = w_prod[dam_pkg::DIV100_SHIFT +: 6];
   assign w_ad     = w13 - 13'(w_op) * 13'd100;

   assign na = acc_ff[WW-1];
   assign nb = m[WW-1];
   assign ma = na ? (WW'(0) - acc_ff) : acc_ff;
   assign mb = nb ? (WW'(0) - m) : m;

   assign rem_sh  = {rem_ff[WW-2:0], quo_ff[WW-1]};
   assign ge      = (rem_sh >= dvs_ff);
   assign rem_new = ge ? (rem_sh - dvs_ff) : rem_sh;
   assign quo_new = {quo_ff[WW-2:0], ge};

   always_comb begin
      rd_addr = pc_ff;
      if (state_ff == S_IDLE && head.item.kind == dam_pkg::K_READ) begin
         rd_addr = head.item.addr;
      end else if (state_ff == S_OPRD) begin
         rd_addr = opa_ff;
      end
   end

   always_comb begin
      we = 1'b0;
      wa = head.item.addr;
      wd = head.item.data;
      if (pop && head.item.kind == dam_pkg::K_WRITE &&
          head.item.addr < AW'(MEM_WORDS)) begin
         we = 1'b1;
      end else if (state_ff == S_EXEC && !bad_ff) begin
         wa = opa_ff;
         if (op_ff == dam_pkg::OP_READ) begin
            we = 1'b1;
            wd = rval_ff;
         end else if (op_ff == dam_pkg::OP_STORE) begin
            we = 1'b1;
            wd = acc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wa] <= wd;
      end
      if (rd_addr < AW'(MEM_WORDS) && mem_vld_ff[rd_addr]) begin
         rd_data_ff <= mem_ff[rd_addr];
      end else begin
         rd_data_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_vld_ff <= '0;
      end else if (we) begin
         mem_vld_ff[wa] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         run_ff       <= dam_pkg::RUN_GO;
         pc_ff        <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (head.valid) begin
                  ov_ff   <= 1'b0;
                  od_ff   <= '0;
                  rval_ff <= head.item.read_value;
                  ign_ff  <= (head.item.kind == dam_pkg::K_EXEC) &&
                             (run_ff != dam_pkg::RUN_GO);
                  if (head.item.kind == dam_pkg::K_READ &&
                      head.item.addr < AW'(MEM_WORDS)) begin
                     oa_ff <= head.item.addr;
                  end else begin
                     oa_ff <= '0;
                  end
                  case (head.item.kind)
                     dam_pkg::K_READ: begin
                        state_ff <= (head.item.addr < AW'(MEM_WORDS)) ? S_MEMRD : S_DONE;
                     end
                     dam_pkg::K_RESTART: begin
                        acc_ff   <= '0;
                        pc_ff    <= '0;
                        run_ff   <= dam_pkg::RUN_GO;
                        state_ff <= S_DONE;
                     end
                     dam_pkg::K_EXEC: begin
                        state_ff <= (run_ff != dam_pkg::RUN_GO) ? S_DONE : S_FETCH;
                     end
                     default: state_ff <= S_DONE;
                  endcase
               end
            end
            S_MEMRD: begin
               ov_ff    <= 1'b1;
               od_ff    <= rd_data_ff;
               state_ff <= S_DONE;
            end
            S_FETCH: begin
               bad_ff   <= word_bad;
               op_ff    <= w_op;
               opa_ff   <= w_ad[AW-1:0];
               state_ff <= S_OPRD;
            end
            S_OPRD: begin
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               state_ff <= (!bad_ff && op_ff == dam_pkg::OP_DIV &&
                            acc_ff != '0 && m != '0) ? S_DIV : S_DONE;
               if (bad_ff) begin
                  run_ff <= dam_pkg::RUN_BADOP;
               end else begin
                  case (op_ff)
                     dam_pkg::OP_READ, dam_pkg::OP_STORE: pc_ff <= pc_next;
                     dam_pkg::OP_WRITE: begin
                        ov_ff <= 1'b1;
                        oa_ff <= opa_ff;
                        od_ff <= m;
                        pc_ff <= pc_next;
                     end
                     dam_pkg::OP_LOAD: begin
                        acc_ff <= m;
                        pc_ff  <= pc_next;
                     end
                     dam_pkg::OP_ADD: begin
                        acc_ff <= acc_ff + m;
                        pc_ff  <= pc_next;
                     end
                     dam_pkg::OP_SUB: begin
                        acc_ff <= acc_ff - m;
                        pc_ff  <= pc_next;
                     end
                     dam_pkg::OP_MUL: begin
                        acc_ff <= acc_ff * m;
                        pc_ff  <= pc_next;
                     end
                     dam_pkg::OP_DIV: begin
                        if (acc_ff == '0 || m == '0) begin
                           run_ff <= dam_pkg::RUN_DIVZ;
                        end else begin
                           quo_ff   <= ma;
                           rem_ff   <= '0;
                           dvs_ff   <= mb;
                           neg_ff   <= na ^ nb;
                           cnt_ff   <= 5'd31;
                        end
                     end
                     dam_pkg::OP_BR: pc_ff <= opa_ff;
                     dam_pkg::OP_BRNEG: pc_ff <= acc_ff[WW-1] ? opa_ff : pc_next;
                     dam_pkg::OP_BRZERO: pc_ff <= (acc_ff == '0) ? opa_ff : pc_next;
                     dam_pkg::OP_HALT: run_ff <= dam_pkg::RUN_HALT;
                     default: run_ff <= dam_pkg::RUN_BADOP;
                  endcase
               end
            end
            S_DIV: begin
               rem_ff <= rem_new;
               quo_ff <= quo_new;
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == 5'd0) begin
                  acc_ff   <= neg_ff ? (WW'(0) - quo_new) : quo_new;
                  pc_ff    <= pc_next;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (slot_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= ign_ff ? dam_pkg::ST_IGNORED
                                          : dam_pkg::STAT_W'(run_ff);
                  rsp_pc_ff     <= pc_ff;
                  rsp_acc_ff    <= acc_ff;
                  rsp_ov_ff     <= ov_ff;
                  rsp_oa_ff     <= oa_ff;
                  rsp_od_ff     <= od_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_pc          = rsp_pc_ff;
   assign rsp_accumulator = rsp_acc_ff;
   assign rsp_out_valid   = rsp_ov_ff;
   assign rsp_out_addr    = rsp_oa_ff;
   assign rsp_out_data    = rsp_od_ff;

endmodule

// ----- hw/rtl/decimal_accumulator_machine.sv -----
// ----------------------------------------------------------------------------
// decimal_accumulator_machine
// Accumulator processor with a word memory; one response per request.
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue and are worked one at a time by the
// executor, which returns one response each. An ordinary instruction
// passes through fetch, decode, operand read, execute and respond. DIVIDE
// adds an iterative divider that forms one quotient bit per cycle. Memory
// reads as zero after reset through per-word valid bits.
module decimal_accumulator_machine #(
   parameter int MEM_WORDS = dam_pkg::MEM_WORDS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_kind,
   input  logic [dam_pkg::ADDR_W-1:0]  req_addr,
   input  logic signed [dam_pkg::WORD_W-1:0] req_data,
   input  logic signed [dam_pkg::WORD_W-1:0] req_read_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [dam_pkg::STAT_W-1:0]  rsp_status,
   output logic [dam_pkg::ADDR_W-1:0]  rsp_pc,
   output logic signed [dam_pkg::WORD_W-1:0] rsp_accumulator,
   output logic                        rsp_out_valid,
   output logic [dam_pkg::ADDR_W-1:0]  rsp_out_addr,
   output logic signed [dam_pkg::WORD_W-1:0] rsp_out_data
);

   dam_pkg::queue_type head;
   logic               pop;

   dam_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_addr       (req_addr),
      .req_data       (req_data),
      .req_read_value (req_read_value),
      .head           (head),
      .pop            (pop)
   );

   dam_back #(.MEM_WORDS(MEM_WORDS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_pc          (rsp_pc),
      .rsp_accumulator (rsp_accumulator),
      .rsp_out_valid   (rsp_out_valid),
      .rsp_out_addr    (rsp_out_addr),
      .rsp_out_data    (rsp_out_data)
   );

endmodule

// ----- hw/rtl/dam_checker.sv -----
// ----------------------------------------------------------------------------
// dam_checker
// Port-level checks of the decimal accumulator machine.
// ----------------------------------------------------------------------------
module dam_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [dam_pkg::STAT_W-1:0]  rsp_status,
   input logic [dam_pkg::ADDR_W-1:0]  rsp_pc,
   input logic                        rsp_out_valid,
   input logic [dam_pkg::ADDR_W-1:0]  rsp_out_addr,
   input logic signed [dam_pkg::WORD_W-1:0] rsp_out_data
);

   a_rst_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_pc))
      else $error("stalled response changed");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pc < dam_pkg::ADDR_W'(dam_pkg::MEM_WORDS))
      else $error("pc out of range");

   a_out_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> rsp_out_addr == '0 && rsp_out_data == '0)
      else $error("output word without out_valid");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= dam_pkg::ST_IGNORED)
      else $error("status code out of range");

endmodule

bind decimal_accumulator_machine dam_checker u_dam_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_status    (rsp_status),
   .rsp_pc        (rsp_pc),
   .rsp_out_valid (rsp_out_valid),
   .rsp_out_addr  (rsp_out_addr),
   .rsp_out_data  (rsp_out_data)
);
